### hdl/tar_header_stream_walker_macros.svh
// Assertion macros shared by the tar header stream walker RTL.
// Each check samples on clk_i and is switched off while rst_ni is low.
`ifndef TAR_HEADER_STREAM_WALKER_MACROS_SVH
`define TAR_HEADER_STREAM_WALKER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a property holds on every enabled clock edge.
`define TAR_HSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition is never seen on an enabled clock edge.
`define TAR_HSW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TAR_HSW_ASSERT(lbl, prop, msg)
`define TAR_HSW_NEVER(lbl, cond, msg)
`endif
`endif

### hdl/tar_hsw_pkg.sv
// Package for the tar header stream walker: widths, header byte positions,
// walker phase codes and the result record type. No dependencies.
`default_nettype none
package tar_hsw_pkg;

  localparam int OFFSET_WIDTH = 40;
  localparam int INDEX_WIDTH  = 16;
  localparam int SIZE_WIDTH   = 33;
  localparam int TYPE_WIDTH   = 8;
  localparam int BYTE_WIDTH   = 8;

  localparam int BLOCK_BYTES  = 512;
  localparam int BIB_WIDTH    = $clog2(BLOCK_BYTES);
  localparam int SUM_WIDTH    = SIZE_WIDTH + 1;
  localparam int SKIP_WIDTH   = SUM_WIDTH - BIB_WIDTH;

  localparam logic [BIB_WIDTH-1:0] BLOCK_LAST = BIB_WIDTH'(BLOCK_BYTES - 1);
  localparam logic [BIB_WIDTH-1:0] SIZE_FIRST = BIB_WIDTH'(124);
  localparam logic [BIB_WIDTH-1:0] SIZE_LAST  = BIB_WIDTH'(124 + 11 - 1);
  localparam logic [BIB_WIDTH-1:0] TYPE_POS   = BIB_WIDTH'(156);

  localparam logic [BYTE_WIDTH-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [BYTE_WIDTH-1:0] ASCII_SEVEN = 8'h37;
  localparam logic [BYTE_WIDTH-1:0] ASCII_NUL   = 8'h00;

  // Walker phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_SKIP   = 3'b010,
    PH_IDLE   = 3'b100
  } phase_e;

  // One result record
  typedef struct packed {
    logic [INDEX_WIDTH-1:0]  entry_num;
    logic [SIZE_WIDTH-1:0]   entry_size;
    logic [TYPE_WIDTH-1:0]   type_flag;
    logic [OFFSET_WIDTH-1:0] data_offset;
    logic                    end_of_archive;
    logic                    bad_size;
  } result_t;

endpackage
`default_nettype wire

### hdl/tar_hsw_in_reg.sv
// Input register of the tar header stream walker: holds one archive byte
// request until the walker takes it. Uses tar_hsw_pkg.
`default_nettype none
module tar_hsw_in_reg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [tar_hsw_pkg::BYTE_WIDTH-1:0] archive_byte_i,
  input  wire logic                               restart_i,
  input  wire logic                               advance_i,
  output logic                                    vld_o,
  output logic [tar_hsw_pkg::BYTE_WIDTH-1:0]      byte_o,
  output logic                                    restart_o
);
  import tar_hsw_pkg::*;

  logic                  vld_q, vld_d;
  logic [BYTE_WIDTH-1:0] byte_q;
  logic                  restart_q;
  logic                  load;

  // Stall only while a held request is not moving on
  assign in_stall_o = vld_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture the payload of an accepted request
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= archive_byte_i;
      restart_q <= restart_i;
    end
  end

  assign vld_o     = vld_q;
  assign byte_o    = byte_q;
  assign restart_o = restart_q;

endmodule
`default_nettype wire

### hdl/tar_hsw_walker.sv
// Header walker of the tar header stream walker: block position, size
// decode, data skipping and result build for one byte. Uses tar_hsw_pkg.
`default_nettype none
`include "tar_header_stream_walker_macros.svh"
module tar_hsw_walker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               step_i,
  input  wire logic [tar_hsw_pkg::BYTE_WIDTH-1:0] byte_i,
  input  wire logic                               restart_i,
  output logic                                    res_vld_o,
  output tar_hsw_pkg::result_t                    res_o
);
  import tar_hsw_pkg::*;

  logic [BIB_WIDTH-1:0]    bib_q, bib_d, cur_bib;
  phase_e                  phase_q, phase_d, cur_phase;
  logic [SIZE_WIDTH-1:0]   acc_q, acc_d, cur_acc, hdr_acc;
  logic [TYPE_WIDTH-1:0]   typ_q, typ_d, cur_typ, hdr_typ;
  logic                    nempty_q, nempty_d, cur_nempty, hdr_nempty;
  logic                    serr_q, serr_d, cur_serr, hdr_serr;
  logic [SKIP_WIDTH-1:0]   skip_q, skip_d, cur_skip, skip_left;
  logic [INDEX_WIDTH-1:0]  cnt_q, cnt_d, cur_cnt;
  logic [OFFSET_WIDTH-1:0] off_q, off_d, cur_off, off_next;
  logic [BYTE_WIDTH-1:0]   digit;
  logic [SUM_WIDTH-1:0]    round_sum;
  logic                    last;
  logic                    in_size;
  logic                    is_octal;
  result_t                 res;
  logic                    res_vld;
  logic                    hdr_end;
  logic                    plain_step;
  logic                    idle_step;

  always_comb begin
    // Apply restart before the byte is looked at
    if (restart_i) begin
      cur_bib    = '0;
      cur_phase  = PH_HEADER;
      cur_acc    = '0;
      cur_typ    = '0;
      cur_nempty = 1'b0;
      cur_serr   = 1'b0;
      cur_skip   = '0;
      cur_cnt    = '0;
      cur_off    = '0;
    end else begin
      cur_bib    = bib_q;
      cur_phase  = phase_q;
      cur_acc    = acc_q;
      cur_typ    = typ_q;
      cur_nempty = nempty_q;
      cur_serr   = serr_q;
      cur_skip   = skip_q;
      cur_cnt    = cnt_q;
      cur_off    = off_q;
    end

    last      = (cur_bib == BLOCK_LAST);
    off_next  = cur_off + OFFSET_WIDTH'(1);
    in_size   = (cur_bib >= SIZE_FIRST) && (cur_bib <= SIZE_LAST);
    is_octal  = byte_i inside {[ASCII_ZERO:ASCII_SEVEN]};
    digit     = byte_i - ASCII_ZERO;

    // Header field capture
    hdr_nempty = (cur_bib == '0) ? (byte_i == ASCII_NUL) : cur_nempty;
    hdr_acc    = cur_acc;
    hdr_serr   = cur_serr;
    if (in_size) begin
      if (is_octal) begin
        hdr_acc = {cur_acc[SIZE_WIDTH-4:0], digit[2:0]};
      end else begin
        hdr_serr = 1'b1;
      end
    end
    hdr_typ   = (cur_bib == TYPE_POS) ? byte_i : cur_typ;
    round_sum = {1'b0, hdr_acc} + SUM_WIDTH'(BLOCK_BYTES - 1);
    skip_left = cur_skip - ((cur_skip != '0) ? SKIP_WIDTH'(1) : '0);

    bib_d    = last ? '0 : cur_bib + BIB_WIDTH'(1);
    phase_d  = cur_phase;
    acc_d    = cur_acc;
    typ_d    = cur_typ;
    nempty_d = cur_nempty;
    serr_d   = cur_serr;
    skip_d   = cur_skip;
    cnt_d    = cur_cnt;
    off_d    = off_next;
    res_vld  = 1'b0;
    res      = '0;

    case (cur_phase)
      PH_HEADER: begin
        acc_d    = hdr_acc;
        typ_d    = hdr_typ;
        nempty_d = hdr_nempty;
        serr_d   = hdr_serr;
        if (last) begin
          res_vld       = 1'b1;
          res.entry_num = cur_cnt;
          if (hdr_nempty) begin
            res.end_of_archive = 1'b1;
            phase_d            = PH_IDLE;
          end else if (hdr_serr) begin
            res.type_flag = hdr_typ;
            res.bad_size  = 1'b1;
            phase_d       = PH_IDLE;
          end else begin
            res.entry_size  = hdr_acc;
            res.type_flag   = hdr_typ;
            res.data_offset = off_next;
            if (cur_cnt != '1) begin
              cnt_d = cur_cnt + INDEX_WIDTH'(1);
            end
            skip_d  = round_sum[SUM_WIDTH-1:BIB_WIDTH];
            phase_d = (round_sum[SUM_WIDTH-1:BIB_WIDTH] != '0) ? PH_SKIP : PH_HEADER;
          end
          // Drop the header fields for the next block
          acc_d    = '0;
          typ_d    = '0;
          nempty_d = 1'b0;
          serr_d   = 1'b0;
        end
      end
      PH_SKIP: begin
        if (last) begin
          skip_d = skip_left;
          if (skip_left == '0) begin
            phase_d = PH_HEADER;
          end
        end
      end
      default: begin
        // Idle: hold everything until restart
        bib_d = cur_bib;
        off_d = cur_off;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bib_q    <= '0;
      phase_q  <= PH_HEADER;
      acc_q    <= '0;
      typ_q    <= '0;
      nempty_q <= 1'b0;
      serr_q   <= 1'b0;
      skip_q   <= '0;
      cnt_q    <= '0;
      off_q    <= '0;
    end else if (step_i) begin
      bib_q    <= bib_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      typ_q    <= typ_d;
      nempty_q <= nempty_d;
      serr_q   <= serr_d;
      skip_q   <= skip_d;
      cnt_q    <= cnt_d;
      off_q    <= off_d;
    end
  end

  assign res_vld_o = res_vld;
  assign res_o     = res;

  // Conditions watched by the checks below
  assign hdr_end    = !restart_i && (bib_q == BLOCK_LAST) && (phase_q == PH_HEADER);
  assign plain_step = step_i && !restart_i;
  assign idle_step  = plain_step && (phase_q == PH_IDLE);

  // A result only comes out of the last byte of a header block
  `TAR_HSW_ASSERT(a_res_on_last, res_vld |-> hdr_end, "result outside header block end")
  // Skipping always has blocks left to skip
  `TAR_HSW_ASSERT(a_skip_nonzero, (phase_q == PH_SKIP) |-> (skip_q != '0), "nothing to skip")
  // Entry count only grows between restarts
  `TAR_HSW_ASSERT(a_cnt_mono, plain_step |=> (cnt_q >= $past(cnt_q)), "entry count fell")
  // Idle walker does not advance through the stream
  `TAR_HSW_ASSERT(a_idle_holds, idle_step |=> ($stable(off_q) && $stable(bib_q)), "idle moved")

endmodule
`default_nettype wire

### hdl/tar_hsw_out_reg.sv
// Result register of the tar header stream walker: holds one result record
// until the downstream side takes it. Uses tar_hsw_pkg.
`default_nettype none
module tar_hsw_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire logic                 res_vld_i,
  input  wire tar_hsw_pkg::result_t res_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output tar_hsw_pkg::result_t      res_o
);
  import tar_hsw_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  // Room when empty or when the held request leaves this cycle
  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = res_vld_i;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture a fresh record
  always_ff @(posedge clk_i) begin
    if (load_i && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

### hdl/tar_header_stream_walker.sv
// Top level of the tar header stream walker: input register, header walker
// and result register. Uses tar_hsw_pkg, tar_hsw_in_reg, tar_hsw_walker, tar_hsw_out_reg.
//
//   channel | direction | handshake                 | payload
//   in      | sink      | in_valid_i / in_stall_o   | archive_byte_i, restart_i
//   out     | source    | out_valid_o / out_stall_i | entry_num_o .. bad_size_o
//
// One archive byte is taken every cycle while no stalled result is held.
// A result is offered from the result register after the last byte of its header
// block is accepted: that byte is held in the input register, then passes
// through the walker into the result register.
// Reset clears all walker state at once; there is no clearing pass.
// A stalled result holds the walker, which then stalls the input after one byte.
`default_nettype none
module tar_header_stream_walker (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [tar_hsw_pkg::BYTE_WIDTH-1:0]   archive_byte_i,
  input  wire logic                                 restart_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [tar_hsw_pkg::INDEX_WIDTH-1:0]       entry_num_o,
  output logic [tar_hsw_pkg::SIZE_WIDTH-1:0]        entry_size_o,
  output logic [tar_hsw_pkg::TYPE_WIDTH-1:0]        type_flag_o,
  output logic [tar_hsw_pkg::OFFSET_WIDTH-1:0]      data_offset_o,
  output logic                                      end_of_archive_o,
  output logic                                      bad_size_o
);
  import tar_hsw_pkg::*;

  logic                  in_vld;
  logic [BYTE_WIDTH-1:0] in_byte;
  logic                  in_restart;
  logic                  out_free;
  logic                  advance;
  logic                  res_vld;
  result_t               res;
  result_t               res_out;

  // Move a byte through the walker when the result register has room
  assign advance = in_vld && out_free;

  tar_hsw_in_reg u_in_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .archive_byte_i (archive_byte_i),
    .restart_i      (restart_i),
    .advance_i      (advance),
    .vld_o          (in_vld),
    .byte_o         (in_byte),
    .restart_o      (in_restart)
  );

  tar_hsw_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte),
    .restart_i (in_restart),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  tar_hsw_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign entry_num_o      = res_out.entry_num;
  assign entry_size_o     = res_out.entry_size;
  assign type_flag_o      = res_out.type_flag;
  assign data_offset_o    = res_out.data_offset;
  assign end_of_archive_o = res_out.end_of_archive;
  assign bad_size_o       = res_out.bad_size;

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for tar_header_stream_walker: feeds tar byte streams,
// predicts every entry record in a byte-level walker model and checks each one.
// Depends on tar_hsw_pkg and the tar_header_stream_walker RTL only.
module tb;
  import tar_hsw_pkg::*;

  // Pacing of the two channels, carried with every request
  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_e;

  typedef struct {
    logic [7:0] data;
    logic       restart;
    pace_e      pace;
    bit         drain;
    bit         hold;
  } stream_byte_t;

  localparam int HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_RECORDS = 48;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [BYTE_WIDTH-1:0]   archive_byte_i = '0;
  logic                    restart_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [INDEX_WIDTH-1:0]  entry_num_o;
  logic [SIZE_WIDTH-1:0]   entry_size_o;
  logic [TYPE_WIDTH-1:0]   type_flag_o;
  logic [OFFSET_WIDTH-1:0] data_offset_o;
  logic                    end_of_archive_o;
  logic                    bad_size_o;

  tar_header_stream_walker uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .archive_byte_i   (archive_byte_i),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .entry_num_o      (entry_num_o),
    .entry_size_o     (entry_size_o),
    .type_flag_o      (type_flag_o),
    .data_offset_o    (data_offset_o),
    .end_of_archive_o (end_of_archive_o),
    .bad_size_o       (bad_size_o)
  );

  stream_byte_t byte_feed[$];
  result_t      due_records[$];

  // Walker model state
  logic [8:0]              w_pos;
  phase_e                  w_phase;
  logic [SIZE_WIDTH-1:0]   w_size;
  logic [7:0]              w_type;
  logic                    w_empty;
  logic                    w_bad;
  logic [24:0]             w_skip;
  logic [INDEX_WIDTH-1:0]  w_count;
  logic [OFFSET_WIDTH-1:0] w_offset;

  // Generator state
  pace_e gen_pace = PACE_FULL;
  bit    next_restart, next_drain, next_hold;
  int    planned;

  pace_e cur_pace = PACE_FULL;
  logic  hold_req = 1'b0;
  logic  hold_seen = 1'b0;
  int    hold_left;
  int    errors, bytes_walked, n_records, n_eoa, n_bad;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void clear_walker();
    w_pos = '0;
    w_phase = PH_HEADER;
    w_size = '0;
    w_type = '0;
    w_empty = 1'b0;
    w_bad = 1'b0;
    w_skip = '0;
    w_count = '0;
    w_offset = '0;
  endfunction

  // Advance the walker model by one accepted byte; queue a record at header end
  function automatic void walk_byte(logic [7:0] b, logic rs);
    result_t rec;
    bit      at_end;
    if (rs) clear_walker();
    if (w_phase == PH_IDLE) return;
    at_end = (w_pos == BLOCK_LAST);
    if (w_phase == PH_HEADER) begin
      if (w_pos == '0) w_empty = (b == ASCII_NUL);
      if (w_pos >= SIZE_FIRST && w_pos <= SIZE_LAST) begin
        if (b >= ASCII_ZERO && b <= ASCII_SEVEN) w_size = {w_size[SIZE_WIDTH-4:0], b[2:0]};
        else w_bad = 1'b1;
      end
      if (w_pos == TYPE_POS) w_type = b;
      if (at_end) begin
        rec = '0;
        rec.entry_num = w_count;
        if (w_empty) begin
          rec.end_of_archive = 1'b1;
          w_phase = PH_IDLE;
        end else if (w_bad) begin
          rec.type_flag = w_type;
          rec.bad_size = 1'b1;
          w_phase = PH_IDLE;
        end else begin
          rec.entry_size = w_size;
          rec.type_flag = w_type;
          rec.data_offset = w_offset + 1'b1;
          if (w_count != '1) w_count = w_count + 1'b1;
          w_skip = 25'((34'(w_size) + 34'(BLOCK_BYTES - 1)) >> BIB_WIDTH);
          w_phase = (w_skip != '0) ? PH_SKIP : PH_HEADER;
        end
        due_records.insert(due_records.size(), rec);
        w_size = '0;
        w_type = '0;
        w_empty = 1'b0;
        w_bad = 1'b0;
      end
    end else if (at_end) begin
      if (w_skip != '0) w_skip = w_skip - 1'b1;
      if (w_skip == '0) w_phase = PH_HEADER;
    end
    w_pos = at_end ? '0 : w_pos + 1'b1;
    w_offset = w_offset + 1'b1;
  endfunction

  function automatic int send_idle_pct(pace_e p);
    case (p)
      PACE_SEND_IDLE: return 70;
      PACE_BOTH:      return 13;
      default:        return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(pace_e p);
    case (p)
      PACE_RECV_STALL: return 70;
      PACE_BOTH:       return 13;
      default:         return 0;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    if (errors < 40) $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_record();
    result_t want;
    if (due_records.size() == 0) begin
      flag_error("entry record with nothing expected");
      return;
    end
    want = due_records.pop_front();
    n_records++;
    if (want.end_of_archive) n_eoa++;
    if (want.bad_size) n_bad++;
    cmp_field("entry_num", 64'(entry_num_o), 64'(want.entry_num));
    cmp_field("entry_size", 64'(entry_size_o), 64'(want.entry_size));
    cmp_field("type_flag", 64'(type_flag_o), 64'(want.type_flag));
    cmp_field("data_offset", 64'(data_offset_o), 64'(want.data_offset));
    cmp_field("end_of_archive", 64'(end_of_archive_o), 64'(want.end_of_archive));
    cmp_field("bad_size", 64'(bad_size_o), 64'(want.bad_size));
  endtask

  // Stream generation
  function automatic void put_byte(logic [7:0] b);
    stream_byte_t it;
    it.data = b;
    it.restart = next_restart;
    it.pace = gen_pace;
    it.drain = next_drain;
    it.hold = next_hold;
    byte_feed.insert(byte_feed.size(), it);
    next_restart = 0;
    next_drain = 0;
    next_hold = 0;
  endfunction

  function automatic void put_data(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(255)));
  endfunction

  // Eleven octal digits, most significant first
  function automatic logic [87:0] octal_digits(logic [SIZE_WIDTH-1:0] size);
    logic [87:0] f;
    for (int i = 0; i < 11; i++) f[87-8*i -: 8] = {5'b00110, size[3*(10-i) +: 3]};
    return f;
  endfunction

  function automatic logic [87:0] octal_with_bad(logic [SIZE_WIDTH-1:0] size, int pos,
                                                 logic [7:0] b);
    logic [87:0] f;
    f = octal_digits(size);
    f[87-8*pos -: 8] = b;
    return f;
  endfunction

  function automatic logic [7:0] non_octal();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b >= ASCII_ZERO && b <= ASCII_SEVEN);
    return b;
  endfunction

  function automatic void put_header(logic [7:0] name0, logic [87:0] digits, logic [7:0] tflag);
    logic [7:0] b;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      b = 8'($urandom_range(255));
      if (i == 0) b = name0;
      else if (i >= SIZE_FIRST && i <= SIZE_LAST) b = digits[87-8*(i-int'(SIZE_FIRST)) -: 8];
      else if (i == TYPE_POS) b = tflag;
      put_byte(b);
    end
    planned++;
  endfunction

  // Well-formed entry: header plus its data rounded up to whole blocks
  function automatic void put_entry(logic [SIZE_WIDTH-1:0] size, logic [7:0] tflag);
    put_header(8'($urandom_range(1, 255)), octal_digits(size), tflag);
    put_data(int'((34'(size) + 34'(BLOCK_BYTES - 1)) >> BIB_WIDTH) * BLOCK_BYTES);
  endfunction

  // Drive requests; predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    stream_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      archive_byte_i <= '0;
      restart_i <= 1'b0;
      cur_pace <= PACE_FULL;
      hold_req <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        walk_byte(archive_byte_i, restart_i);
        bytes_walked++;
      end
      // Offer the next request unless the sender idles or waits for a drain
      if (!in_valid_i || !in_stall_o) begin
        if (byte_feed.size() != 0 && !(byte_feed[0].drain && due_records.size() != 0) &&
            $urandom_range(99) >= send_idle_pct(byte_feed[0].pace)) begin
          nxt = byte_feed.pop_front();
          in_valid_i <= 1'b1;
          archive_byte_i <= nxt.data;
          restart_i <= nxt.restart;
          cur_pace <= nxt.pace;
          if (nxt.hold) hold_req <= ~hold_req;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check records and drive the result-side stall, with long hold-offs on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_record();
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct(cur_pace));
      end
    end
  end

  initial begin : stimulus
    int pick;
    int roll;
    clear_walker();

    // Directed streams, several drained before the next
    next_restart = 1;
    put_entry(33'd0, 8'h30);
    next_drain = 1;
    put_entry(33'd1, 8'h00);
    next_drain = 1;
    next_hold = 1;
    put_entry(33'd512, 8'hFF);
    next_drain = 1;
    put_entry(33'd513, 8'h35);
    put_entry(33'o1777, 8'h32);
    // largest size; cut the skip short by restart
    next_drain = 1;
    put_header(8'hFF, octal_digits('1), 8'h37);
    put_data(600);
    // truncated header gives nothing
    next_restart = 1;
    put_data(300);
    // non-octal digits at either end and just outside the digit range
    next_restart = 1;
    put_header(8'h41, octal_with_bad(33'd100, 0, 8'h38), 8'h30);
    put_data(100);
    next_restart = 1;
    next_drain = 1;
    put_header(8'h41, octal_with_bad(33'd7, 10, ASCII_NUL), 8'h35);
    next_restart = 1;
    put_header(8'h01, octal_with_bad(33'd0, 5, 8'hFF), 8'hFF);
    next_restart = 1;
    put_header(8'h7F, octal_with_bad(33'd0, 3, 8'h2F), 8'h00);
    // empty name wins over a bad digit
    next_restart = 1;
    put_header(ASCII_NUL, octal_with_bad(33'd9, 2, 8'h20), 8'h30);
    // end of archive after entries, trailing bytes ignored, restart while idle
    next_restart = 1;
    next_drain = 1;
    put_entry(33'd40, 8'h30);
    put_entry(33'd0, 8'h31);
    put_header(ASCII_NUL, octal_digits(33'd0), 8'h00);
    put_data(50);
    next_restart = 1;
    put_entry(33'd1024, 8'h30);

    // Random archives: mostly well-formed entries, some end markers, errors and cut-offs
    planned = 0;
    for (int h = 0; planned < RANDOM_RECORDS; h++) begin
      if (h % 6 == 0) begin
        gen_pace = pace_e'((h / 6) % 4);
        next_drain = 1;
      end
      if (h == 2 || h == 26) next_hold = 1;
      pick = $urandom_range(99);
      if (pick < 5) next_restart = 1;
      if (pick < 72) begin
        roll = $urandom_range(99);
        if (roll < 25) begin
          put_entry(33'd0, 8'($urandom_range(255)));
        end else if (roll < 40) begin
          put_entry(33'(BLOCK_BYTES * $urandom_range(1, 3)), 8'($urandom_range(255)));
        end else if (roll < 90) begin
          put_entry(33'($urandom_range(1, 2048)), 8'($urandom_range(255)));
        end else begin
          put_header(8'($urandom_range(1, 255)), octal_digits(33'({$urandom, $urandom})),
                     8'($urandom_range(255)));
          put_data($urandom_range(1, 700));
          next_restart = 1;
        end
      end else if (pick < 80) begin
        if ($urandom_range(1)) put_header(ASCII_NUL, octal_digits(33'($urandom)), 8'hAA);
        else put_header(ASCII_NUL, octal_with_bad(33'($urandom), $urandom_range(10),
                                                  non_octal()), 8'($urandom_range(255)));
        put_data($urandom_range(0, 40));
        next_restart = 1;
      end else if (pick < 90) begin
        put_header(8'($urandom_range(1, 255)),
                   octal_with_bad(33'($urandom_range(4000)), $urandom_range(10), non_octal()),
                   8'($urandom_range(255)));
        put_data($urandom_range(0, 40));
        next_restart = 1;
      end else begin
        put_data($urandom_range(1, BLOCK_BYTES - 1));
        next_restart = 1;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to go in and every record to come out
    while (byte_feed.size() != 0 || in_valid_i || due_records.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("walked %0d archive bytes; checked %0d entry records", bytes_walked, n_records);
    $display("of which %0d end-of-archive and %0d bad-size; %0d mismatches",
             n_eoa, n_bad, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/tar_hsw_pkg.sv
hdl/tar_hsw_in_reg.sv
hdl/tar_hsw_walker.sv
hdl/tar_hsw_out_reg.sv
hdl/tar_header_stream_walker.sv
tb/sv/tb.sv
